/* hdl/rgb_to_hsl_8bit_defines.svh */
// ----------------------------------------------------------------------------
// rgb_to_hsl_8bit_defines
// assertion macros shared by the colour conversion pipeline
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_8BIT_DEFINES_SVH
`define RGB_TO_HSL_8BIT_DEFINES_SVH
`ifndef SYNTH
// check that is switched off while reset is held
`define RTHSL_CHK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rthsl check failed");
// check that also covers the reset cycles
`define RTHSL_CHK_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("rthsl reset check failed");
`else
`define RTHSL_CHK(lbl, prop)
`define RTHSL_CHK_RST(lbl, prop)
`endif
`endif

/* hdl/rthsl_pkg.sv */
// ----------------------------------------------------------------------------
// rthsl_pkg
// types, sector codes and the divider step of the rgb to hsl pipeline
// ----------------------------------------------------------------------------
package rthsl_pkg;

    // which channel holds the maximum
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    // number of two-bit divider stages
    localparam int DIV_STAGES = 4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] mx;
        logic [7:0] mn;
        logic [1:0] sec;
    } t_sorted;

    typedef struct packed {
        logic [7:0]  d;
        logic [7:0]  light;
        logic [7:0]  den;
        logic [10:0] n;
    } t_scaled;

    typedef struct packed {
        logic [7:0]  light;
        logic [7:0]  sat_rem;
        logic [7:0]  sat_lo;
        logic [7:0]  sat_q;
        logic [7:0]  sat_dvs;
        logic [10:0] hue_rem;
        logic [7:0]  hue_lo;
        logic [7:0]  hue_q;
        logic [10:0] hue_dvs;
    } t_div;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [11:0] div_step(input logic [11:0] shifted,
                                             input logic [10:0] dvs);
        logic [12:0] diff;
        diff = {1'b0, shifted} - {2'b00, dvs};
        if (!diff[12]) begin
            return {1'b1, diff[10:0]};
        end else begin
            return {1'b0, shifted[10:0]};
        end
    endfunction

endpackage

/* hdl/rthsl_sort.sv */
// ----------------------------------------------------------------------------
// rthsl_sort
// first stage: maximum, minimum and hue sector of the pixel
// ----------------------------------------------------------------------------
module rthsl_sort (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    output logic               o_vld,
    output rthsl_pkg::t_sorted o_data
);
    import rthsl_pkg::*;

    logic    r_vld;
    t_sorted r_data;
    t_sorted n_data;

    always_comb begin
        n_data.red   = i_red;
        n_data.green = i_green;
        n_data.blue  = i_blue;
        // ties go to red first, then green
        priority if (i_red >= i_green && i_red >= i_blue) begin
            n_data.sec = SEC_RED;
            n_data.mx  = i_red;
            n_data.mn  = (i_green < i_blue) ? i_green : i_blue;
        end else if (i_green >= i_blue) begin
            n_data.sec = SEC_GREEN;
            n_data.mx  = i_green;
            n_data.mn  = (i_red < i_blue) ? i_red : i_blue;
        end else begin
            n_data.sec = SEC_BLUE;
            n_data.mx  = i_blue;
            n_data.mn  = (i_red < i_green) ? i_red : i_green;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

/* hdl/rthsl_scale.sv */
// ----------------------------------------------------------------------------
// rthsl_scale
// second stage: chroma, lightness, saturation divisor and hue numerator
// ----------------------------------------------------------------------------
module rthsl_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  rthsl_pkg::t_sorted i_data,
    output logic               o_vld,
    output rthsl_pkg::t_scaled o_data
);
    import rthsl_pkg::*;

    logic         r_vld;
    t_scaled      r_data;
    t_scaled      n_data;
    logic [7:0]   d;
    logic [8:0]   s;
    logic [8:0]   s_inv;
    logic [10:0]  d6;
    logic [10:0]  base;
    logic [8:0]   diff;
    logic [11:0]  n_sum;
    logic [11:0]  n_fix;

    always_comb begin
        d     = i_data.mx - i_data.mn;
        s     = {1'b0, i_data.mx} + {1'b0, i_data.mn};
        s_inv = 9'd510 - s;
        d6    = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
        unique case (i_data.sec)
            SEC_RED: begin
                base = 11'd0;
                diff = {1'b0, i_data.green} - {1'b0, i_data.blue};
            end
            SEC_GREEN: begin
                base = {2'b00, d, 1'b0};
                diff = {1'b0, i_data.blue} - {1'b0, i_data.red};
            end
            default: begin
                base = {1'b0, d, 2'b00};
                diff = {1'b0, i_data.red} - {1'b0, i_data.green};
            end
        endcase
        n_sum = {1'b0, base} + {{3{diff[8]}}, diff};
        // negative red sector wraps round the circle
        n_fix = n_sum[11] ? (n_sum + {1'b0, d6}) : n_sum;

        n_data.d     = d;
        n_data.light = s[8:1];
        n_data.den   = (s < 9'd255) ? s[7:0] : s_inv[7:0];
        n_data.n     = n_fix[10:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

/* hdl/rthsl_setup.sv */
// ----------------------------------------------------------------------------
// rthsl_setup
// third stage: scales numerators by 255 and loads both dividers
// ----------------------------------------------------------------------------
module rthsl_setup (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  rthsl_pkg::t_scaled i_data,
    output logic               o_vld,
    output rthsl_pkg::t_div    o_data
);
    import rthsl_pkg::*;

    logic        r_vld;
    t_div        r_data;
    t_div        n_data;
    logic [15:0] num_sat;
    logic [18:0] num_hue;
    logic [10:0] d6;
    logic        grey;

    always_comb begin
        // 255*x as x*256 - x
        num_sat = {i_data.d, 8'h00} - {8'h00, i_data.d};
        num_hue = {i_data.n, 8'h00} - {8'h00, i_data.n};
        d6      = {1'b0, i_data.d, 2'b00} + {2'b00, i_data.d, 1'b0};
        grey    = (i_data.d == 8'd0);

        n_data.light   = i_data.light;
        // upper half is already below the divisor, so eight steps suffice
        n_data.sat_rem = num_sat[15:8];
        n_data.sat_lo  = num_sat[7:0];
        n_data.sat_q   = 8'd0;
        n_data.hue_rem = num_hue[18:8];
        n_data.hue_lo  = num_hue[7:0];
        n_data.hue_q   = 8'd0;
        // grey pixel: zero numerators over one give zero
        n_data.sat_dvs = grey ? 8'd1 : i_data.den;
        n_data.hue_dvs = grey ? 11'd1 : d6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

/* hdl/rthsl_div_stage.sv */
// ----------------------------------------------------------------------------
// rthsl_div_stage
// two quotient bits of the saturation and hue dividers per stage
// ----------------------------------------------------------------------------
`include "rgb_to_hsl_8bit_defines.svh"

module rthsl_div_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  rthsl_pkg::t_div i_data,
    output logic            o_vld,
    output rthsl_pkg::t_div o_data
);
    import rthsl_pkg::*;

    logic        r_vld;
    t_div        r_data;
    t_div        n_data;
    logic [11:0] sat_a;
    logic [11:0] sat_b;
    logic [11:0] hue_a;
    logic [11:0] hue_b;

    always_comb begin
        sat_a = div_step({3'b000, i_data.sat_rem, i_data.sat_lo[7]},
                         {3'b000, i_data.sat_dvs});
        sat_b = div_step({3'b000, sat_a[7:0], i_data.sat_lo[6]},
                         {3'b000, i_data.sat_dvs});
        hue_a = div_step({i_data.hue_rem, i_data.hue_lo[7]}, i_data.hue_dvs);
        hue_b = div_step({hue_a[10:0], i_data.hue_lo[6]}, i_data.hue_dvs);

        n_data         = i_data;
        n_data.sat_rem = sat_b[7:0];
        n_data.sat_lo  = {i_data.sat_lo[5:0], 2'b00};
        n_data.sat_q   = {i_data.sat_q[5:0], sat_a[11], sat_b[11]};
        n_data.hue_rem = hue_b[10:0];
        n_data.hue_lo  = {i_data.hue_lo[5:0], 2'b00};
        n_data.hue_q   = {i_data.hue_q[5:0], hue_a[11], hue_b[11]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

    // restoring division keeps the partial remainder below the divisor
    `RTHSL_CHK(a_sat_rem_below_dvs, r_vld |-> (r_data.sat_rem < r_data.sat_dvs))
    `RTHSL_CHK(a_hue_rem_below_dvs, r_vld |-> (r_data.hue_rem < r_data.hue_dvs))

endmodule

/* hdl/rgb_to_hsl_8bit.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsl_8bit
// pipelined 8-bit rgb to hue, saturation and lightness conversion
// ----------------------------------------------------------------------------
// input channel: i_valid with i_red, i_green, i_blue; o_stall holds it off.
// output channel: o_valid with o_hue_out, o_sat_out, o_light_out; i_stall
// from the receiver holds the result steady on the ports.
// a transfer happens on a rising edge where valid is high and stall is low.
// the stages in order are sort, scale, divider setup and four divider stages,
// each retiring two quotient bits of both the saturation and hue divisions.
// throughput is one pixel per clock; every stage has its own valid bit and
// loads whenever it is empty or its successor moves on, so bubbles close up
// and o_stall rises only once the whole pipe is full behind a stalled result.
// reset empties the pipe: all valid bits clear and o_valid drops.
// hue is floor(255*h6/6) with h6 in [0,6), so it never exceeds 254; grey
// pixels give zero hue and saturation.
// ----------------------------------------------------------------------------
`include "rgb_to_hsl_8bit_defines.svh"

module rgb_to_hsl_8bit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_hue_out,
    output logic [7:0] o_sat_out,
    output logic [7:0] o_light_out
);
    import rthsl_pkg::*;

    localparam int NUM_STG = DIV_STAGES + 3;

    logic [NUM_STG-1:0] w_vld;
    logic [NUM_STG-1:0] w_en;
    t_sorted            w_sorted;
    t_scaled            w_scaled;
    t_div               w_div [0:DIV_STAGES];

    // a stage may load when empty or when its successor takes its item
    always_comb begin
        w_en[NUM_STG-1] = !w_vld[NUM_STG-1] || !i_stall;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_en[k] = !w_vld[k] || w_en[k+1];
        end
    end

    rthsl_sort u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en[0]),
        .i_vld   (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_vld   (w_vld[0]),
        .o_data  (w_sorted)
    );

    rthsl_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en[1]),
        .i_vld   (w_vld[0]),
        .i_data  (w_sorted),
        .o_vld   (w_vld[1]),
        .o_data  (w_scaled)
    );

    rthsl_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en[2]),
        .i_vld   (w_vld[1]),
        .i_data  (w_scaled),
        .o_vld   (w_vld[2]),
        .o_data  (w_div[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        rthsl_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[g+3]),
            .i_vld   (w_vld[g+2]),
            .i_data  (w_div[g]),
            .o_vld   (w_vld[g+3]),
            .o_data  (w_div[g+1])
        );
    end

    assign o_stall     = !w_en[0];
    assign o_valid     = w_vld[NUM_STG-1];
    assign o_hue_out   = w_div[DIV_STAGES].hue_q;
    assign o_sat_out   = w_div[DIV_STAGES].sat_q;
    assign o_light_out = w_div[DIV_STAGES].light;

    `RTHSL_CHK_RST(a_reset_empties, !i_rst_n |=> !o_valid)
    `RTHSL_CHK(a_stall_only_when_full, o_stall |-> (o_valid && i_stall))
    `RTHSL_CHK(a_hue_in_range, o_valid |-> (o_hue_out != 8'hff))

endmodule
